/* rtl/ppte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ppte_pkg;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_WRITE,
    OP_EVAL
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_SRD,
    ST_SCMP,
    ST_AXIS,
    ST_HA,
    ST_HB,
    ST_HC,
    ST_OUT
  } state_e;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_WRITE  = 2'd2;
  localparam logic [1:0] FUNC_EVAL   = 2'd3;

  localparam logic [1:0] CFG_AXIS_COUNT     = 2'd0;
  localparam logic [1:0] CFG_POLY_DEGREE    = 2'd1;
  localparam logic [1:0] CFG_SKIP_THRESHOLD = 2'd2;

  localparam logic [2:0] MAX_DERIV = 3'd4;

  typedef struct packed {
    logic [3:0]  axis_count;
    logic [2:0]  poly_degree;
    logic [15:0] skip_threshold;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [5:0]         segment;
    logic [2:0]         axis;
    logic [2:0]         power;
    logic signed [31:0] operand;
    logic [31:0]        position;
    logic [2:0]         deriv_order;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         axis_index;
    logic signed [31:0] result_value;
    logic [5:0]         segment_index;
    logic               saturated;
    logic               empty_error;
    logic               last;
  } res_t;

  // Falling-factorial weight i*(i-1)*...*(i-d+1) for d up to four.
  function automatic logic [15:0] falling(input logic [3:0] i, input logic [2:0] d);
    logic [15:0] w;
    w = 16'd1;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < d) begin
        w = 16'(w * 16'(i - 4'(k)));
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/ppte_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ppte_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         segment;
  logic [2:0]         axis;
  logic [2:0]         power;
  logic signed [31:0] operand;
  logic [31:0]        position;
  logic [2:0]         deriv_order;

  modport source (output valid, func, segment, axis, power, operand, position, deriv_order,
                  input ready);
  modport sink (input valid, func, segment, axis, power, operand, position, deriv_order,
                output ready);
endinterface

interface ppte_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         axis_index;
  logic signed [31:0] result_value;
  logic [5:0]         segment_index;
  logic               saturated;
  logic               empty_error;
  logic               last;

  modport source (output valid, axis_index, result_value, segment_index, saturated,
                  empty_error, last, input ready);
  modport sink (input valid, axis_index, result_value, segment_index, saturated,
                empty_error, last, output ready);
endinterface

interface ppte_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/piecewise_poly_trajectory_eval.sv */
// Channel   Modport  Carries
// in_i      sink     func, segment, axis, power, operand, position, deriv_order
// out_o     source   axis_index, result_value, segment_index, saturated, empty_error, last
// cfg_i     sink     index, data (always ready)
//
// Clear, append and coefficient write are done in the back end as the queue pops them. An
// evaluation first finds the segment, where needed by a search of the start times, one read
// and compare per step; then per axis it runs HA, HB and HC per coefficient on one RAM port.
// Reset clears the segment list and restores the register defaults; the stores need none.
// A two-entry queue accepts items while the back end works or the output stalls, until full.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_poly_trajectory_eval #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_AXES     = 8,
  parameter int unsigned MAX_DEGREE   = 7
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ppte_in_if.sink    in_i,
  ppte_out_if.source out_o,
  ppte_cfg_if.sink   cfg_i
);

  ppte_pkg::cfg_t cfg_q;
  ppte_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_count     <= 4'd1;
      cfg_q.poly_degree    <= 3'd3;
      cfg_q.skip_threshold <= 16'd1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ppte_pkg::CFG_AXIS_COUNT:     cfg_q.axis_count     <= cfg_i.data[3:0];
        ppte_pkg::CFG_POLY_DEGREE:    cfg_q.poly_degree    <= cfg_i.data[2:0];
        ppte_pkg::CFG_SKIP_THRESHOLD: cfg_q.skip_threshold <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  ppte_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_AXES     (MAX_AXES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ppte_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_AXES     (MAX_AXES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* rtl/ppte_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppte_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/ppte_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppte_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  ppte_pkg::cmd_t     data_i,
  output logic               full_o,
  output logic               valid_o,
  output ppte_pkg::cmd_t     data_o,
  input  wire logic          pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ppte_pkg::cmd_t  slot_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wptr_q + 1'b1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CW'(cnt_q - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ppte_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppte_front #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_AXES     = 8,
  parameter int unsigned MAX_DEGREE   = 7
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ppte_in_if.sink         in_i,
  input  ppte_pkg::cfg_t  cfg_i,
  output logic            cmd_valid_o,
  output ppte_pkg::cmd_t  cmd_o,
  input  wire logic       cmd_pop_i
);

  ppte_pkg::cmd_t cmd;
  logic           full;
  logic           in_range;
  logic           keep_len;

  // A coefficient write outside the store and a duration not above the skip threshold are dropped
  // here; the back end still drops an append that would overfill the list or overflow the total.
  always_comb begin
    in_range = (32'(in_i.segment) < MAX_SEGMENTS) && (32'(in_i.axis) < MAX_AXES)
               && (32'(in_i.power) <= MAX_DEGREE);
    keep_len = !in_i.operand[31] && (in_i.operand > $signed({16'b0, cfg_i.skip_threshold}));
    cmd.segment     = in_i.segment;
    cmd.axis        = in_i.axis;
    cmd.power       = in_i.power;
    cmd.operand     = in_i.operand;
    cmd.position    = in_i.position;
    cmd.deriv_order = in_i.deriv_order;
    unique case (in_i.func)
      ppte_pkg::FUNC_CLEAR:  cmd.op = ppte_pkg::OP_CLEAR;
      ppte_pkg::FUNC_APPEND: cmd.op = keep_len ? ppte_pkg::OP_APPEND : ppte_pkg::OP_NOP;
      ppte_pkg::FUNC_WRITE:  cmd.op = in_range ? ppte_pkg::OP_WRITE : ppte_pkg::OP_NOP;
      ppte_pkg::FUNC_EVAL:   cmd.op = ppte_pkg::OP_EVAL;
      default:               cmd.op = ppte_pkg::OP_NOP;
    endcase
  end

  assign in_i.ready = !full;

  ppte_fifo #(.DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_i.valid),
    .data_i  (cmd),
    .full_o  (full),
    .valid_o (cmd_valid_o),
    .data_o  (cmd_o),
    .pop_i   (cmd_pop_i)
  );

endmodule

`default_nettype wire

/* rtl/ppte_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppte_back #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_AXES     = 8,
  parameter int unsigned MAX_DEGREE   = 7
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  ppte_pkg::cfg_t  cfg_i,
  input  wire logic       cmd_valid_i,
  input  ppte_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  ppte_out_if.source      out_o
);

  localparam int unsigned SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned AX_W  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int unsigned DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AXC_W = $clog2(MAX_AXES + 1);
  localparam int unsigned CA_W  = SEG_W + AX_W + DEG_W;

  ppte_pkg::state_e   state_q, state_d;
  ppte_pkg::cmd_t     cmd_q;
  ppte_pkg::res_t     res_q;
  logic [CNT_W-1:0]   cnt_q, k_q;
  logic [31:0]        total_q, start_q, offs_q;
  logic [SEG_W-1:0]   idx_q;
  logic [AXC_W-1:0]   ax_q;
  logic [DEG_W-1:0]   i_q;
  logic signed [31:0] acc_q;
  logic               sat_q, empty_q;
  logic signed [64:0] prod_q;
  logic signed [48:0] pf_q, cw_q;
  logic [15:0]        w_q;

  logic [AXC_W-1:0]   naxes;
  logic [DEG_W-1:0]   deg;
  logic               skip_eval, ax_last, app_ok, gt, step_last;
  logic [32:0]        app_sum;
  logic signed [49:0] sum;
  logic signed [31:0] sum_sat;
  logic               sum_clip;
  logic signed [32:0] offs_s;

  logic               seg_we, coef_we;
  logic [SEG_W-1:0]   seg_waddr, len_raddr, start_raddr;
  logic [CA_W-1:0]    coef_waddr, coef_raddr;
  logic [31:0]        start_rdata, len_rdata, coef_rdata;

  always_comb begin
    if (cfg_i.axis_count == '0) begin
      naxes = AXC_W'(1);
    end else if (32'(cfg_i.axis_count) > MAX_AXES) begin
      naxes = AXC_W'(MAX_AXES);
    end else begin
      naxes = AXC_W'(cfg_i.axis_count);
    end
    deg = (32'(cfg_i.poly_degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
                                                : DEG_W'(cfg_i.poly_degree);
  end

  assign skip_eval = (cmd_q.deriv_order > ppte_pkg::MAX_DERIV)
                     || (32'(cmd_q.deriv_order) > 32'(deg));
  assign ax_last   = (32'(ax_q) + 32'd1 == 32'(naxes));
  assign app_sum   = {1'b0, total_q} + {1'b0, cmd_i.operand};
  assign app_ok    = (32'(cnt_q) < MAX_SEGMENTS) && !app_sum[32];
  assign gt        = (cmd_q.position > start_rdata);
  assign step_last = !gt || (32'(k_q) + 32'd1 == 32'(cnt_q));
  assign offs_s    = $signed({1'b0, offs_q});

  always_comb begin
    sum      = 50'(pf_q) + 50'(cw_q);
    sum_clip = 1'b0;
    sum_sat  = 32'(sum);
    if (sum > 50'sd2147483647) begin
      sum_sat  = 32'sh7FFFFFFF;
      sum_clip = 1'b1;
    end else if (sum < -50'sd2147483648) begin
      sum_sat  = 32'sh80000000;
      sum_clip = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppte_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.op == ppte_pkg::OP_EVAL) begin
          if (cnt_q == '0 || cmd_i.position <= {16'b0, cfg_i.skip_threshold}) begin
            state_d = ppte_pkg::ST_AXIS;
          end else if (cmd_i.position >= total_q) begin
            state_d = ppte_pkg::ST_LEN;
          end else if (cnt_q == CNT_W'(1)) begin
            state_d = ppte_pkg::ST_AXIS;
          end else begin
            state_d = ppte_pkg::ST_SRD;
          end
        end
      end
      ppte_pkg::ST_LEN:  state_d = ppte_pkg::ST_AXIS;
      ppte_pkg::ST_SRD:  state_d = ppte_pkg::ST_SCMP;
      ppte_pkg::ST_SCMP: state_d = step_last ? ppte_pkg::ST_AXIS : ppte_pkg::ST_SRD;
      ppte_pkg::ST_AXIS: state_d = (empty_q || skip_eval) ? ppte_pkg::ST_OUT : ppte_pkg::ST_HA;
      ppte_pkg::ST_HA:   state_d = ppte_pkg::ST_HB;
      ppte_pkg::ST_HB:   state_d = ppte_pkg::ST_HC;
      ppte_pkg::ST_HC: begin
        state_d = (32'(i_q) == 32'(cmd_q.deriv_order)) ? ppte_pkg::ST_OUT : ppte_pkg::ST_HA;
      end
      ppte_pkg::ST_OUT: begin
        if (out_o.ready) begin
          state_d = ax_last ? ppte_pkg::ST_IDLE : ppte_pkg::ST_AXIS;
        end
      end
      default: state_d = ppte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o   = (state_q == ppte_pkg::ST_IDLE) && cmd_valid_i;
    seg_we      = cmd_pop_o && (cmd_i.op == ppte_pkg::OP_APPEND) && app_ok;
    seg_waddr   = SEG_W'(cnt_q);
    coef_we     = cmd_pop_o && (cmd_i.op == ppte_pkg::OP_WRITE);
    coef_waddr  = {SEG_W'(cmd_i.segment), AX_W'(cmd_i.axis), DEG_W'(cmd_i.power)};
    len_raddr   = SEG_W'(CNT_W'(cnt_q - 1'b1));
    start_raddr = SEG_W'(k_q);
    coef_raddr  = {idx_q, AX_W'(ax_q), i_q};
    out_o.valid = (state_q == ppte_pkg::ST_OUT);
  end

  assign out_o.axis_index    = res_q.axis_index;
  assign out_o.result_value  = res_q.result_value;
  assign out_o.segment_index = res_q.segment_index;
  assign out_o.saturated     = res_q.saturated;
  assign out_o.empty_error   = res_q.empty_error;
  assign out_o.last          = res_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppte_pkg::ST_IDLE;
      cnt_q   <= '0;
      total_q <= '0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        if (cmd_i.op == ppte_pkg::OP_CLEAR) begin
          cnt_q   <= '0;
          total_q <= '0;
        end else if (seg_we) begin
          cnt_q   <= CNT_W'(cnt_q + 1'b1);
          total_q <= app_sum[31:0];
        end
        empty_q <= (cnt_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ppte_pkg::ST_IDLE: begin
        cmd_q   <= cmd_i;
        ax_q    <= '0;
        k_q     <= CNT_W'(1);
        start_q <= '0;
        if (cmd_i.position <= {16'b0, cfg_i.skip_threshold}) begin
          idx_q  <= '0;
          offs_q <= '0;
        end else if (cmd_i.position >= total_q) begin
          idx_q <= len_raddr;
        end else begin
          idx_q  <= '0;
          offs_q <= cmd_i.position;
        end
      end
      ppte_pkg::ST_LEN: offs_q <= len_rdata;
      ppte_pkg::ST_SRD: begin
      end
      ppte_pkg::ST_SCMP: begin
        if (gt) begin
          idx_q   <= SEG_W'(k_q);
          start_q <= start_rdata;
        end
        offs_q <= cmd_q.position - (gt ? start_rdata : start_q);
        k_q    <= CNT_W'(k_q + 1'b1);
      end
      ppte_pkg::ST_AXIS: begin
        i_q   <= deg;
        acc_q <= '0;
        sat_q <= 1'b0;
        res_q.axis_index    <= 3'(ax_q);
        res_q.result_value  <= '0;
        res_q.segment_index <= empty_q ? 6'd0 : 6'(idx_q);
        res_q.saturated     <= 1'b0;
        res_q.empty_error   <= empty_q;
        res_q.last          <= ax_last;
      end
      ppte_pkg::ST_HA: begin
        prod_q <= acc_q * offs_s;
        w_q    <= ppte_pkg::falling(4'(i_q), cmd_q.deriv_order);
      end
      ppte_pkg::ST_HB: begin
        pf_q <= prod_q[64:16];
        cw_q <= 49'($signed(coef_rdata) * $signed({1'b0, w_q}));
      end
      ppte_pkg::ST_HC: begin
        acc_q <= sum_sat;
        sat_q <= sat_q || sum_clip;
        i_q   <= DEG_W'(i_q - 1'b1);
        res_q.result_value <= sum_sat;
        res_q.saturated    <= sat_q || sum_clip;
      end
      ppte_pkg::ST_OUT: begin
        if (out_o.ready) begin
          ax_q <= AXC_W'(ax_q + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  ppte_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS), .AW(SEG_W)) u_starts (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (total_q),
    .raddr_i (start_raddr),
    .rdata_o (start_rdata)
  );

  ppte_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS), .AW(SEG_W)) u_lengths (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (cmd_i.operand),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  ppte_ram #(.WIDTH(32), .DEPTH(2 ** CA_W), .AW(CA_W)) u_coeffs (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (cmd_i.operand),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

endmodule

`default_nettype wire

/* rtl/ppte_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_value_i,
  input wire logic [5:0]  out_segment_i,
  input wire logic        out_saturated_i,
  input wire logic        out_empty_i
);

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  a_value_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i))
    else $error("stalled result value changed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> out_value_i == 32'd0 && out_segment_i == 6'd0)
    else $error("empty-table result not zero");

  a_empty_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> !out_saturated_i)
    else $error("empty-table result flagged as saturated");

endmodule

bind piecewise_poly_trajectory_eval ppte_checker u_ppte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_value_i     (out_o.result_value),
  .out_segment_i   (out_o.segment_index),
  .out_saturated_i (out_o.saturated),
  .out_empty_i     (out_o.empty_error)
);

`default_nettype wire
